// File: hw/rtl/lpr_pkg.sv
// lpr_pkg: shared constants and angle helpers for the lidar relative-time block.
// No dependencies; imported by the top level and by lpr_cordic, lpr_front and lpr_back.
package lpr_pkg;

	// Item kinds carried in tuser
	localparam logic MODE_HEADER = 1'b0;
	localparam logic MODE_POINT  = 1'b1;

	// Register index (word address bit of paddr)
	localparam logic REG_MIN_RANGE = 1'b0;

	localparam logic [18:0] MIN_RANGE_RESET = 19'd1024;

	// Angle constants in Q30 radians
	localparam logic [35:0] Q30_PI       = 36'd3373259426;
	localparam logic [35:0] Q30_HALF_PI  = 36'd1686629713;
	localparam logic [35:0] Q30_3HALF_PI = 36'd5059889139;
	localparam logic [35:0] Q30_2PI      = 36'd6746518852;
	localparam logic [35:0] Q30_3PI      = 36'd10119778278;

	localparam int ATAN_LEN = 24;

	// atan(2^-i) in Q30
	localparam logic [31:0] ATAN_Q30 [ATAN_LEN] = '{
		32'd843314857, 32'd497837829, 32'd263043836, 32'd133525158, 32'd67021686,
		32'd33543515, 32'd16775850, 32'd8388437, 32'd4194282, 32'd2097149,
		32'd1048575, 32'd524287, 32'd262143, 32'd131071, 32'd65535, 32'd32767,
		32'd16383, 32'd8191, 32'd4095, 32'd2047, 32'd1023, 32'd511, 32'd255, 32'd127
	};

	// Round a Q30 angle to af fraction bits
	function automatic logic [35:0] q30_to_ang(input logic [35:0] v, input int af);
		q30_to_ang = (v + (36'd1 << (29 - af))) >> (30 - af);
	endfunction

	function automatic logic [35:0] atan_ang(input logic [4:0] idx, input int af);
		atan_ang = q30_to_ang({4'd0, ATAN_Q30[idx]}, af);
	endfunction

endpackage

// File: hw/rtl/lidar_point_relative_time.sv
// lidar_point_relative_time: top level, stream ports, APB register and front/back split.
// Depends on lpr_pkg, lpr_front, lpr_queue, lpr_back.
//
// Stamps each lidar point of a sweep with its relative time in the rotation (Q1.14).
// A header request (tuser = 0) carries the first and last point of the sweep; the block
// takes their azimuths, folds the end azimuth into start+pi..start+3pi and divides
// out the span reciprocal. Point requests (tuser = 1) get azimuth -atan2(y,x),
// unwrapped against the start or end azimuth, and are dropped if closer than
// min_range (register at byte address 0, reset 1024). The front runs an
// iterative CORDIC, one micro-rotation a cycle: one pass for a point, two for a
// header (first, then last point). The back steps a point through unwrap, multiply
// and rounding states, and a header through its bit-serial reciprocal divider.
// A two-entry queue between them and a registered output let either side
// stall alone; the front takes a new item only once it has queued the last one.
module lidar_point_relative_time #(
	parameter int COORD_WIDTH     = 20,
	parameter int ANGLE_FRAC_BITS = 12,
	parameter int CORDIC_STAGES   = 16
) (
	input  logic clk,
	input  logic arst_n,
	// tdata: x_pos, y_pos, z_pos, last_x, last_y (low to high), zero padded
	input  logic [((5*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
	// tuser: mode
	input  logic                               s_axis_tuser,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// tdata: out_x, out_y, out_z, rel_time (low to high), zero padded
	output logic [((3*COORD_WIDTH+23)/8)*8-1:0] m_axis_tdata,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import lpr_pkg::*;

	localparam int CW    = COORD_WIDTH;
	localparam int AF    = ANGLE_FRAC_BITS;
	localparam int AW    = AF + 6;   // Q5.AF plus headroom for unwrapped angles
	localparam int QW    = 3 * CW + 2 * AW + 2;
	localparam int OUT_W = ((3 * CW + 23) / 8) * 8;

	logic [18:0] min_range_q;
	logic [37:0] min_sq_q;        // min_range squared, kept alongside the register
	logic        cfg_wr;

	logic              q_push, q_full, q_pop, q_empty;
	logic [QW-1:0]     q_wdata, q_head;
	logic signed [CW-1:0] o_x, o_y, o_z;
	logic signed [15:0]   o_rt;

	// APB: zero wait states, only word 0 is backed by a register
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_MIN_RANGE);
	assign prdata = (paddr[2] == REG_MIN_RANGE) ? 32'(min_range_q) : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_range_q <= MIN_RANGE_RESET;
			min_sq_q    <= 38'(MIN_RANGE_RESET) * 38'(MIN_RANGE_RESET);
		end else if (cfg_wr) begin
			min_range_q <= pwdata[18:0];
			min_sq_q    <= 38'(pwdata[18:0]) * 38'(pwdata[18:0]);
		end
	end

	lpr_front #(.CW(CW), .AW(AW), .AF(AF), .STAGES(CORDIC_STAGES), .QW(QW)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_mode  (s_axis_tuser),
		.in_x     (s_axis_tdata[CW-1:0]),
		.in_y     (s_axis_tdata[2*CW-1:CW]),
		.in_z     (s_axis_tdata[3*CW-1:2*CW]),
		.in_lx    (s_axis_tdata[4*CW-1:3*CW]),
		.in_ly    (s_axis_tdata[5*CW-1:4*CW]),
		.min_sq   (min_sq_q),
		.q_push   (q_push),
		.q_data   (q_wdata),
		.q_full   (q_full)
	);

	lpr_queue #(.W(QW)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_wdata),
		.full      (q_full),
		.pop       (q_pop),
		.head      (q_head),
		.empty     (q_empty)
	);

	lpr_back #(.CW(CW), .AW(AW), .AF(AF), .QW(QW)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_head    (q_head),
		.q_empty   (q_empty),
		.q_pop     (q_pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_x     (o_x),
		.out_y     (o_y),
		.out_z     (o_z),
		.rel_time  (o_rt)
	);

	assign m_axis_tdata = OUT_W'({o_rt, o_z, o_y, o_x});

endmodule

// File: hw/rtl/lpr_cordic.sv
// lpr_cordic: iterative CORDIC vectoring unit, one micro-rotation per cycle.
// Depends on lpr_pkg (stage angle table, pi).
module lpr_cordic #(
	parameter int CW     = 20,
	parameter int AW     = 18,
	parameter int AF     = 12,
	parameter int STAGES = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic signed [CW-1:0] x_in,
	input  logic signed [CW-1:0] y_in,
	output logic                 done,
	output logic signed [AW-1:0] angle
);
	import lpr_pkg::*;

	localparam int XW = CW + 3;
	localparam int SW = (STAGES > 1) ? $clog2(STAGES) : 1;
	localparam logic signed [AW-1:0] PI_A = AW'(q30_to_ang(Q30_PI, AF));

	logic signed [XW-1:0] x_q, y_q, dx, dy, xe, ye;
	logic signed [AW-1:0] z_q, stage_a;
	logic [SW-1:0]        cnt_q;
	logic                 busy_q, done_q, zero_q;

	assign xe      = XW'(x_in);
	assign ye      = XW'(y_in);
	assign dx      = y_q >>> cnt_q;
	assign dy      = x_q >>> cnt_q;
	assign stage_a = AW'(atan_ang(5'(cnt_q), AF));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == SW'(STAGES - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			zero_q <= (x_in == '0) && (y_in == '0);
			// fold left half-plane by +-pi
			if (x_in < 0) begin
				x_q <= -xe;
				y_q <= -ye;
				z_q <= (y_in >= 0) ? PI_A : -PI_A;
			end else begin
				x_q <= xe;
				y_q <= ye;
				z_q <= '0;
			end
		end else if (busy_q) begin
			if (!y_q[XW-1]) begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + stage_a;
			end else begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - stage_a;
			end
		end
	end

	assign done  = done_q;
	assign angle = zero_q ? '0 : z_q;

endmodule

// File: hw/rtl/lpr_queue.sv
// lpr_queue: two-entry FIFO between front and back.
// No package dependency.
module lpr_queue #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] head,
	output logic         empty
);
	logic [W-1:0] mem_q [2];
	logic         wr_q, rd_q;
	logic [1:0]   cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_data;
	end

	assign head  = mem_q[rd_q];
	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);

endmodule

// File: hw/rtl/lpr_front.sv
// lpr_front: accepts items, runs atan2 and the squared range test, queues the result.
// Depends on lpr_pkg and lpr_cordic.
module lpr_front #(
	parameter int CW     = 20,
	parameter int AW     = 18,
	parameter int AF     = 12,
	parameter int STAGES = 16,
	parameter int QW     = 3 * 20 + 2 * 18 + 2
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 in_mode,
	input  logic signed [CW-1:0] in_x,
	input  logic signed [CW-1:0] in_y,
	input  logic signed [CW-1:0] in_z,
	input  logic signed [CW-1:0] in_lx,
	input  logic signed [CW-1:0] in_ly,
	input  logic [37:0]          min_sq,
	output logic                 q_push,
	output logic [QW-1:0]        q_data,
	input  logic                 q_full
);
	import lpr_pkg::*;

	localparam int R2W  = 2 * CW + 2;
	localparam int CMPW = (R2W > 38) ? R2W : 38;

	typedef enum logic [1:0] {F_IDLE, F_CORD_A, F_CORD_B, F_PUSH} fstate_t;
	fstate_t state_q;

	logic                 mode_q, keep_q;
	logic signed [CW-1:0] x_q, y_q, z_q, lx_q, ly_q, sq_op;
	logic signed [AW-1:0] ang_a_q, ang_b_q, c_angle;
	logic [2*CW-1:0]      sq_s1;
	logic [R2W-1:0]       r2_q;
	logic [2:0]           sq_cnt_q;
	logic                 accept, c_start, c_done;
	logic signed [CW-1:0] c_x, c_y;

	assign in_ready = (state_q == F_IDLE);
	assign accept   = in_valid && in_ready;
	assign c_start  = accept || (state_q == F_CORD_A && c_done && mode_q == MODE_HEADER);
	assign c_x      = (state_q == F_IDLE) ? in_x : lx_q;
	assign c_y      = (state_q == F_IDLE) ? in_y : ly_q;

	lpr_cordic #(.CW(CW), .AW(AW), .AF(AF), .STAGES(STAGES)) u_cordic (
		.clk(clk), .arst_n(arst_n), .start(c_start), .x_in(c_x), .y_in(c_y),
		.done(c_done), .angle(c_angle)
	);

	always_comb begin
		case (sq_cnt_q)
			3'd0:    sq_op = x_q;
			3'd1:    sq_op = y_q;
			default: sq_op = z_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			case (state_q)
				F_IDLE:   if (accept) state_q <= F_CORD_A;
				F_CORD_A: if (c_done) state_q <= (mode_q == MODE_HEADER) ? F_CORD_B : F_PUSH;
				F_CORD_B: if (c_done) state_q <= F_PUSH;
				F_PUSH:   if (!q_full) state_q <= F_IDLE;
				default:  state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q   <= in_mode;
			x_q      <= in_x;
			y_q      <= in_y;
			z_q      <= in_z;
			lx_q     <= in_lx;
			ly_q     <= in_ly;
			sq_cnt_q <= '0;
			r2_q     <= '0;
		end
		if (state_q == F_CORD_A) begin
			// x^2, y^2, z^2 through one multiplier, each product accumulated in the next cycle
			if (sq_cnt_q < 3'd3) sq_s1 <= (2*CW)'(sq_op * sq_op);
			if (sq_cnt_q != 3'd0 && sq_cnt_q <= 3'd3) r2_q <= r2_q + R2W'(sq_s1);
			if (sq_cnt_q != 3'd4) sq_cnt_q <= sq_cnt_q + 3'd1;
			if (c_done) begin
				ang_a_q <= -c_angle;
				keep_q  <= (CMPW'(r2_q) >= CMPW'(min_sq));
			end
		end
		if (state_q == F_CORD_B && c_done) ang_b_q <= -c_angle;
	end

	assign q_push = (state_q == F_PUSH) && !q_full;
	assign q_data = {keep_q, mode_q, ang_b_q, ang_a_q, z_q, y_q, x_q};

endmodule

// File: hw/rtl/lpr_back.sv
// lpr_back: scan state, span reciprocal divider, azimuth unwrap and rel_time output.
// Depends on lpr_pkg.
module lpr_back #(
	parameter int CW = 20,
	parameter int AW = 18,
	parameter int AF = 12,
	parameter int QW = 3 * 20 + 2 * 18 + 2
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [QW-1:0]        q_head,
	input  logic                 q_empty,
	output logic                 q_pop,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic signed [CW-1:0] out_x,
	output logic signed [CW-1:0] out_y,
	output logic signed [CW-1:0] out_z,
	output logic signed [15:0]   rel_time
);
	import lpr_pkg::*;

	localparam int UW = AW + 2;
	localparam int PW = UW + 20;
	localparam int RW = AW + 1;
	localparam int NB = 19 + AF;
	localparam int CNTW = $clog2(NB);
	localparam logic signed [UW-1:0] PI_U     = UW'(q30_to_ang(Q30_PI, AF));
	localparam logic signed [UW-1:0] HPI_U    = UW'(q30_to_ang(Q30_HALF_PI, AF));
	localparam logic signed [UW-1:0] THPI_U   = UW'(q30_to_ang(Q30_3HALF_PI, AF));
	localparam logic signed [UW-1:0] TWOPI_U  = UW'(q30_to_ang(Q30_2PI, AF));
	localparam logic signed [UW-1:0] THREEPI_U = UW'(q30_to_ang(Q30_3PI, AF));
	localparam logic signed [PW-1:0] RND      = PW'(1) <<< (AF + 3);
	localparam logic signed [PW-1:0] SAT_HI   = PW'(32767);
	localparam logic signed [PW-1:0] SAT_LO   = PW'(-32768);

	typedef enum logic [2:0] {B_IDLE, B_HDR, B_DIV, B_UNW, B_MUL, B_RND} bstate_t;
	bstate_t state_q;

	logic signed [CW-1:0] x_q, y_q, z_q;
	logic signed [AW-1:0] ang_a_q, ang_b_q, start_q, end_q;
	logic                 keep_q, mode_h, half_q;
	logic [17:0]          recip_q, quo_q;
	logic [AW-1:0]        span_q;
	logic [RW-1:0]        rem_q;
	logic [RW:0]          rem_nx;
	logic [CNTW-1:0]      bit_q;
	logic signed [UW-1:0] a_q, a0, a1, b0, b1, s_u, e_u, e0, d0, e_fold;
	logic                 hp_set, rem_ge;
	logic signed [PW-1:0] prod_s1, rnd, sat;

	assign mode_h = q_head[QW-2];
	assign q_pop  = (state_q == B_IDLE) && !q_empty;

	// header fold of the end azimuth
	assign e0 = UW'(ang_b_q) + TWOPI_U;
	assign d0 = e0 - UW'(ang_a_q);
	always_comb begin
		if (d0 > THREEPI_U) e_fold = e0 - TWOPI_U;
		else if (d0 < PI_U) e_fold = e0 + TWOPI_U;
		else e_fold = e0;
	end

	// restoring divide of 2^(18+AF) by span, one quotient bit a cycle
	assign rem_nx = {rem_q, (bit_q == CNTW'(18 + AF))};
	assign rem_ge = rem_nx >= (RW+1)'(span_q);

	// point unwrap
	assign s_u = UW'(start_q);
	assign e_u = UW'(end_q);
	assign a0  = UW'(ang_a_q);
	assign b0  = a0 + TWOPI_U;
	always_comb begin
		if (a0 < s_u - HPI_U) a1 = a0 + TWOPI_U;
		else if (a0 > s_u + THPI_U) a1 = a0 - TWOPI_U;
		else a1 = a0;
		if (b0 < e_u - THPI_U) b1 = b0 + TWOPI_U;
		else if (b0 > e_u + HPI_U) b1 = b0 - TWOPI_U;
		else b1 = b0;
		hp_set = (a1 - s_u) > PI_U;
	end

	assign rnd = (prod_s1 + RND) >>> (AF + 4);
	always_comb begin
		if (rnd > SAT_HI) sat = SAT_HI;
		else if (rnd < SAT_LO) sat = SAT_LO;
		else sat = rnd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= B_IDLE;
			start_q   <= '0;
			end_q     <= '0;
			recip_q   <= '0;
			half_q    <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (state_q == B_RND && keep_q && (!out_valid || out_ready)) out_valid <= 1'b1;
			else if (out_valid && out_ready) out_valid <= 1'b0;
			case (state_q)
				B_IDLE: begin
					if (!q_empty) state_q <= (mode_h == MODE_HEADER) ? B_HDR : B_UNW;
				end
				B_HDR: begin
					start_q <= ang_a_q;
					end_q   <= AW'(e_fold);
					half_q  <= 1'b0;
					state_q <= B_DIV;
				end
				B_DIV: begin
					if (bit_q == '0) begin
						recip_q <= {quo_q[16:0], rem_ge};
						state_q <= B_IDLE;
					end
				end
				B_UNW: begin
					if (!half_q && hp_set) half_q <= 1'b1;
					state_q <= B_MUL;
				end
				B_MUL: state_q <= B_RND;
				B_RND: begin
					if (!keep_q || !out_valid || out_ready) state_q <= B_IDLE;
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			{keep_q, ang_b_q, ang_a_q, z_q, y_q, x_q} <=
				{q_head[QW-1], q_head[QW-3:0]};
		end
		case (state_q)
			B_HDR: begin
				span_q <= AW'(e_fold - UW'(ang_a_q));
				rem_q  <= '0;
				quo_q  <= '0;
				bit_q  <= CNTW'(NB - 1);
			end
			B_DIV: begin
				rem_q <= rem_ge ? RW'(rem_nx - (RW+1)'(span_q)) : RW'(rem_nx);
				quo_q <= {quo_q[16:0], rem_ge};
				bit_q <= bit_q - 1'b1;
			end
			B_UNW: a_q <= half_q ? b1 : a1;
			B_MUL: prod_s1 <= PW'((UW+1)'(a_q) - (UW+1)'(start_q)) * PW'($signed({1'b0, recip_q}));
			B_RND: begin
				if (keep_q && (!out_valid || out_ready)) begin
					out_x    <= x_q;
					out_y    <= y_q;
					out_z    <= z_q;
					rel_time <= 16'(sat);
				end
			end
			default: ;
		endcase
	end

endmodule
